// File: rtl/upc_pkg.sv
`default_nettype none
package upc_pkg;

	localparam logic [7:0] PCT   = 8'h25;
	localparam logic [7:0] TILDE = 8'h7e;
	localparam logic [7:0] HI_MASK = 8'hf0;
	localparam logic [7:0] LO_MASK = 8'h0f;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// escape progress in decode mode
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	localparam int unsigned MAX_RES = 3;

	typedef logic [7:0] byte_t;

	function automatic logic is_unreserved(input byte_t b);
		logic r;
		r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
			(b >= 8'h61 && b <= 8'h7a) ||
			b == 8'h2d || b == 8'h2e || b == 8'h5f || b == TILDE;
		return r;
	endfunction

	function automatic logic is_hex(input byte_t b);
		logic r;
		r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
		return r;
	endfunction

	// digit value of a hex character (letters of either case)
	function automatic logic [3:0] hex_nib(input byte_t b);
		logic [3:0] r;
		if (b <= 8'h39) begin
			r = b[3:0];
		end else begin
			r = b[3:0] + 4'd9;
		end
		return r;
	endfunction

	// "0123456789ABCDEF"
	function automatic byte_t hex_upper(input logic [3:0] n);
		byte_t r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h37 + {4'd0, n};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/upc_in_if.sv
`default_nettype none
interface upc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// File: rtl/upc_out_if.sv
`default_nettype none
interface upc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;

	modport source (output valid, output out_byte, output run_last, output text_done,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input text_done,
		output ready);
endinterface
`default_nettype wire

// File: rtl/url_percent_codec_core.sv
`default_nettype none
// The first result byte of an item is valid in the cycle after the item is accepted
// when the output is idle; behind a group still draining it waits until that group is done.
// Items are taken one per cycle while each gives at most one byte and the output stays ready;
// an item that expands to N bytes emits them one result byte per cycle while the output is ready.
// A two-entry result group buffer lets the next item in while a group is still draining.
// Reset (arst_n low): encode mode, no escape held, result buffers empty.
module url_percent_codec_core
	import upc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	upc_in_if.sink      text,
	upc_out_if.source   result
);

	logic       mode_q;
	logic [1:0] pend_q;
	byte_t      held_q;

	// group being emitted
	logic       g_valid_q;
	byte_t      g_byte_q [MAX_RES];
	logic [1:0] g_n_q;
	logic [1:0] g_idx_q;
	logic       g_eot_q;

	// group waiting behind it
	logic       w_valid_q;
	byte_t      w_byte_q [MAX_RES];
	logic [1:0] w_n_q;
	logic       w_eot_q;

	byte_t      nb [MAX_RES];
	logic [1:0] nn;
	logic [1:0] pend_n;
	byte_t      held_n;

	logic accept, g_last, g_take, g_free, new_grp;
	byte_t b;

	assign b = text.in_byte;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			nb[i] = PCT;
		end
		nn = 2'd0;
		pend_n = pend_q;
		held_n = held_q;
		if (mode_q == MODE_ENCODE) begin
			pend_n = PEND_NONE;
			if (is_unreserved(b)) begin
				nb[0] = b;
				nn = 2'd1;
			end else begin
				nb[0] = PCT;
				nb[1] = hex_upper(4'((b & HI_MASK) >> 4));
				nb[2] = hex_upper(4'(b & LO_MASK));
				nn = 2'd3;
			end
		end else begin
			case (pend_q)
				PEND_PCT: begin
					if (is_hex(b)) begin
						held_n = b;
						pend_n = PEND_DIGIT;
					end else if (b == PCT) begin
						nn = 2'd1;
						pend_n = PEND_PCT;
					end else begin
						nb[1] = b;
						nn = 2'd2;
						pend_n = PEND_NONE;
					end
				end
				PEND_DIGIT: begin
					if (is_hex(held_q) && is_hex(b)) begin
						nb[0] = {hex_nib(held_q), hex_nib(b)};
						nn = 2'd1;
						pend_n = PEND_NONE;
					end else if (b == PCT) begin
						nb[1] = held_q;
						nn = 2'd2;
						pend_n = PEND_PCT;
					end else begin
						nb[1] = held_q;
						nb[2] = b;
						nn = 2'd3;
						pend_n = PEND_NONE;
					end
				end
				default: begin
					if (b == PCT) begin
						pend_n = PEND_PCT;
					end else begin
						nb[0] = b;
						nn = 2'd1;
					end
				end
			endcase
		end
		// end of text: flush whatever escape is still held
		if (text.end_of_text) begin
			if (pend_n != PEND_NONE && nn != 2'd3) begin
				nb[nn] = PCT;
				nn = nn + 2'd1;
			end
			if (pend_n == PEND_DIGIT && nn != 2'd3) begin
				nb[nn] = held_n;
				nn = nn + 2'd1;
			end
			pend_n = PEND_NONE;
			held_n = 8'h00;
		end
	end

	assign text.ready = !w_valid_q;
	assign accept  = text.valid && text.ready;
	assign new_grp = accept && (nn != 2'd0);

	assign g_last = (g_idx_q == g_n_q - 2'd1);
	assign g_take = result.valid && result.ready;
	assign g_free = !g_valid_q || (g_take && g_last);

	assign result.valid     = g_valid_q;
	assign result.out_byte  = g_byte_q[g_idx_q];
	assign result.run_last  = g_last;
	assign result.text_done = g_last && g_eot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ENCODE;
			pend_q    <= PEND_NONE;
			held_q    <= 8'h00;
			g_valid_q <= 1'b0;
			g_idx_q   <= 2'd0;
			w_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
				pend_q <= PEND_NONE;
				held_q <= 8'h00;
			end else if (accept) begin
				pend_q <= pend_n;
				held_q <= held_n;
			end

			if (g_free) begin
				g_idx_q <= 2'd0;
				if (w_valid_q) begin
					g_valid_q <= 1'b1;
					w_valid_q <= 1'b0;
				end else begin
					g_valid_q <= new_grp;
				end
			end else begin
				if (g_take) begin
					g_idx_q <= g_idx_q + 2'd1;
				end
				if (new_grp) begin
					w_valid_q <= 1'b1;
				end
			end
		end
	end

	// group payload, no reset
	always_ff @(posedge clk) begin
		if (g_free) begin
			if (w_valid_q) begin
				g_byte_q <= w_byte_q;
				g_n_q    <= w_n_q;
				g_eot_q  <= w_eot_q;
			end else if (new_grp) begin
				g_byte_q <= nb;
				g_n_q    <= nn;
				g_eot_q  <= text.end_of_text;
			end
		end else if (new_grp) begin
			w_byte_q <= nb;
			w_n_q    <= nn;
			w_eot_q  <= text.end_of_text;
		end
	end

endmodule
`default_nettype wire
